// ===== design/blr_pkg.sv =====
// Shared types, constants and helpers for the line rasterizer.
package blr_pkg;

  localparam int COORD_BITS = 16;
  localparam int DELTA_W    = COORD_BITS + 1;
  localparam int ERR_W      = COORD_BITS + 2;
  localparam int DIM_W      = 15;
  localparam int CMP_W      = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DIM_W-1:0]      dim_t;

  typedef enum logic [0:0] {
    ST_READY = 1'b0,
    ST_SETUP = 1'b1
  } state_e;

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  // Controller to datapath
  typedef struct packed {
    logic load_start;
    logic load_err;
    logic do_step;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_diff;
    logic step_fin;
  } dp_stat_t;

  function automatic logic inside_img(coord_t c, dim_t lim);
    logic [CMP_W-1:0] cu;
    logic [CMP_W-1:0] lu;
    cu = CMP_W'(c);
    lu = CMP_W'(lim);
    return !c[COORD_BITS-1] && (cu < lu);
  endfunction

endpackage

// ===== design/blr_dp.sv =====
// Datapath: endpoints, deltas, error term, config registers and output payload.
module blr_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  blr_pkg::dp_cmd_t                  cmd_i,
  output blr_pkg::dp_stat_t                 stat_o,
  input  logic [blr_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic                              cfg_valid_i,
  input  logic [blr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [blr_pkg::DIM_W-1:0]         cfg_data_i,
  output logic [blr_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic                              out_inside_o,
  output logic                              out_last_o
);
  import blr_pkg::*;

  dim_t width_q, height_q;

  coord_t cur_x_q, cur_y_q, goal_x_q, goal_y_q;
  logic [DELTA_W-1:0] adx_q, ady_q;
  logic x_neg_q, y_neg_q;
  logic signed [ERR_W-1:0] err_q;

  coord_t pix_x_q, pix_y_q;
  logic   inside_q, last_q;

  // start decode
  coord_t x0, y0, x1, y1;
  logic signed [DELTA_W-1:0] dxs, dys;
  logic [DELTA_W-1:0] adx, ady;
  logic start_diff;

  // step decode
  logic signed [ERR_W:0] e2, ndy, pdx;
  logic mv_x, mv_y;
  logic signed [ERR_W-1:0] err_n;
  coord_t nx, ny;
  logic fin;

  always_comb begin
    x0 = in_data_i[COORD_BITS-1:0];
    y0 = in_data_i[2*COORD_BITS-1:COORD_BITS];
    x1 = in_data_i[3*COORD_BITS-1:2*COORD_BITS];
    y1 = in_data_i[4*COORD_BITS-1:3*COORD_BITS];
    dxs = $signed({x1[COORD_BITS-1], x1}) - $signed({x0[COORD_BITS-1], x0});
    dys = $signed({y1[COORD_BITS-1], y1}) - $signed({y0[COORD_BITS-1], y0});
    adx = dxs[DELTA_W-1] ? DELTA_W'(-dxs) : DELTA_W'(dxs);
    ady = dys[DELTA_W-1] ? DELTA_W'(-dys) : DELTA_W'(dys);
    start_diff = (x0 != x1) || (y0 != y1);
  end

  always_comb begin
    e2    = $signed({err_q, 1'b0});
    ndy   = -$signed({2'b00, ady_q});
    pdx   = $signed({2'b00, adx_q});
    mv_x  = e2 > ndy;
    mv_y  = e2 < pdx;
    err_n = err_q - (mv_x ? $signed({1'b0, ady_q}) : '0)
                  + (mv_y ? $signed({1'b0, adx_q}) : '0);
    nx = cur_x_q;
    ny = cur_y_q;
    if (mv_x) begin
      nx = x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
    end
    if (mv_y) begin
      ny = y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
    end
    fin = (nx == goal_x_q) && (ny == goal_y_q);
  end

  assign stat_o.start_diff = start_diff;
  assign stat_o.step_fin   = fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      adx_q    <= '0;
      ady_q    <= '0;
      x_neg_q  <= 1'b0;
      y_neg_q  <= 1'b0;
      err_q    <= '0;
      pix_x_q  <= '0;
      pix_y_q  <= '0;
      inside_q <= 1'b0;
      last_q   <= 1'b0;
    end else if (cmd_i.load_start) begin
      cur_x_q  <= x0;
      cur_y_q  <= y0;
      goal_x_q <= x1;
      goal_y_q <= y1;
      adx_q    <= adx;
      ady_q    <= ady;
      x_neg_q  <= dxs[DELTA_W-1] || (dxs == '0);
      y_neg_q  <= dys[DELTA_W-1] || (dys == '0);
      pix_x_q  <= x1;
      pix_y_q  <= y1;
      inside_q <= inside_img(x1, width_q) && inside_img(y1, height_q);
      last_q   <= !start_diff;
    end else if (cmd_i.do_step) begin
      cur_x_q  <= nx;
      cur_y_q  <= ny;
      err_q    <= err_n;
      pix_x_q  <= cur_x_q;
      pix_y_q  <= cur_y_q;
      inside_q <= inside_img(cur_x_q, width_q) && inside_img(cur_y_q, height_q);
      last_q   <= fin;
    end else if (cmd_i.load_err) begin
      err_q <= $signed({1'b0, adx_q}) - $signed({1'b0, ady_q});
    end
  end

  assign out_data_o   = OUT_DATA_W'({pix_y_q, pix_x_q});
  assign out_inside_o = inside_q;
  assign out_last_o   = last_q;

endmodule

// ===== design/blr_ctrl.sv =====
// Controller: command decode, busy tracking, setup state and output valid.
module blr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output blr_pkg::dp_cmd_t   cmd_o,
  input  blr_pkg::dp_stat_t  stat_i
);
  import blr_pkg::*;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire, is_start, is_step;

  assign in_ready_o = (state_q == ST_READY) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_start   = in_fire && (in_cmd_i == CMD_START);
  assign is_step    = in_fire && (in_cmd_i == CMD_STEP) && busy_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_READY: if (is_start) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_READY;
      default:  state_d = ST_READY;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.load_start = is_start;
    cmd_o.do_step    = is_step;
    cmd_o.load_err   = (state_q == ST_SETUP);
    busy_d = busy_q;
    if (is_start) begin
      busy_d = stat_i.start_diff;
    end else if (is_step && stat_i.step_fin) begin
      busy_d = 1'b0;
    end
    out_valid_d = (out_valid_q && !out_ready_i) || is_start || is_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READY;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_start_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_start |=> (state_q == ST_SETUP) && out_valid_q)
    else $error("start did not enter setup with a result");

  a_idle_step_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_cmd_i == CMD_STEP) && !busy_q && !out_valid_q) |=> !out_valid_q)
    else $error("step while idle produced an item");

  a_fin_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_step && stat_i.step_fin) |=> !busy_q)
    else $error("line end left block busy");

  a_no_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_start |=> !in_ready_o)
    else $error("item accepted during setup");

endmodule

// ===== design/bresenham_line_rasterizer_top.sv =====
// Top level of the line rasterizer with inside check.
// A result is registered when its item is accepted and offered in the next cycle.
// A start item is followed by a setup state that loads the error term from the deltas
//   and holds off new items; one pixel per clock while stepping and not stalled.
// Reset: image size returns to 640 x 480, the block goes idle and the output empties.
// A new item enters only while the output register is empty or drains in the same cycle.
module bresenham_line_rasterizer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata from bit 0: x_start, y_start, x_end, y_end
  input  logic [blr_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: cmd (0 start, 1 step)
  input  logic                              s_axis_tuser_i,
  // result items
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata from bit 0: pixel_x, pixel_y
  output logic [blr_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // tuser: inside_res
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  // register writes: index 0 image_width, 1 image_height
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [blr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [blr_pkg::DIM_W-1:0]         cfg_data_i
);
  import blr_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Controller: decode start/step, hold the busy flag, own the output valid.
  blr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // Datapath: deltas, error rule, point advance, inside check, result payload.
  blr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .in_data_i    (s_axis_tdata_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_data_o   (m_axis_tdata_o),
    .out_inside_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule
